// File: hw/rtl/indexed_insert_remove_array_unit_assert.svh
// assertion macros for the indexed insert remove array unit
`ifndef INDEXED_INSERT_REMOVE_ARRAY_UNIT_ASSERT_SVH
`define INDEXED_INSERT_REMOVE_ARRAY_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define IIRA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("iira assertion failed");

// next-cycle implication, disabled in reset
`define IIRA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("iira assertion failed");

`endif

// File: hw/rtl/iira_pkg.sv
// types and constants of the indexed insert remove array unit
`default_nettype none

package iira_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

    localparam logic [2:0] KIND_READ   = 3'd0;
    localparam logic [2:0] KIND_WRITE  = 3'd1;
    localparam logic [2:0] KIND_INSERT = 3'd2;
    localparam logic [2:0] KIND_APPEND = 3'd3;
    localparam logic [2:0] KIND_REMOVE = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         kind;
        logic [7:0]         index;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
        logic [4:0]         count;
        logic               is_empty;
    } t_out_item;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_INSERT,
        CELL_REMOVE
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic [IDX_W-1:0]   pos;
        logic signed [31:0] word;
    } t_cell_cmd;

endpackage

`default_nettype wire

// File: hw/rtl/indexed_insert_remove_array_unit.sv
// top level of the indexed insert remove array unit
//
// A bounded ordered list of up to DEPTH signed 32-bit words held in a row of
// cells. Each input item is one operation (read, write, insert before, append,
// remove) and gives exactly one output item with the read value, a status, the
// count after the operation and an empty flag.
// Both channels use valid/ready. An item is taken whenever the output register
// is empty or being emptied in the same cycle, so one item per cycle is
// sustained unless the receiver stalls; all cells shift together on acceptance.
// The result is registered and shown in the cycle after acceptance.
// When the receiver stalls, the result is held and no new item is taken.
// Reset (synchronous, active low) empties the list and the output register;
// cell contents are left as they are and are only read below the count.
`default_nettype none

module indexed_insert_remove_array_unit
    import iira_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  wire       i_out_ready,
    output t_out_item o_out_item
);

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_out_valid;
    t_out_item          r_out_item;
    t_out_item          n_out_item;

    logic               accept;
    logic               in_range;
    logic               full;
    logic [IDX_W-1:0]   idx_sel;
    logic [1:0]         status;
    logic signed [31:0] rd_value;
    t_cell_cmd          cmd;
    logic signed [31:0] entry [DEPTH];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign in_range   = CMP_W'(i_in_item.index) < CMP_W'(r_count);
    assign full       = r_count == CNT_W'(DEPTH);
    assign idx_sel    = i_in_item.index[IDX_W-1:0];

    always_comb begin
        n_count  = r_count;
        status   = ST_OK;
        rd_value = '0;
        cmd.op   = CELL_HOLD;
        cmd.pos  = idx_sel;
        cmd.word = i_in_item.value;
        unique case (i_in_item.kind)
            KIND_READ: begin
                if (in_range) begin
                    rd_value = entry[idx_sel];
                end else begin
                    status = ST_RANGE;
                end
            end
            KIND_WRITE: begin
                if (in_range) begin
                    cmd.op = CELL_WRITE;
                end else begin
                    status = ST_RANGE;
                end
            end
            KIND_INSERT: begin
                if (!in_range) begin
                    status = ST_RANGE;
                end else if (full) begin
                    status = ST_FULL;
                end else begin
                    cmd.op  = CELL_INSERT;
                    n_count = r_count + CNT_W'(1);
                end
            end
            KIND_APPEND: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    cmd.op  = CELL_WRITE;
                    cmd.pos = IDX_W'(r_count);
                    n_count = r_count + CNT_W'(1);
                end
            end
            KIND_REMOVE: begin
                if (!in_range) begin
                    status = ST_RANGE;
                end else begin
                    cmd.op  = CELL_REMOVE;
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
        if (!accept) begin
            cmd.op  = CELL_HOLD;
            n_count = r_count;
        end
        n_out_item.read_value = rd_value;
        n_out_item.status     = status;
        n_out_item.count      = 5'(n_count);
        n_out_item.is_empty   = n_count == '0;
    end

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic signed [31:0] left;
        logic signed [31:0] right;
        if (k == 0) begin : g_first
            assign left = '0;
        end else begin : g_left
            assign left = entry[k-1];
        end
        if (k == DEPTH - 1) begin : g_last
            assign right = '0;
        end else begin : g_right
            assign right = entry[k+1];
        end
        iira_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd),
            .i_pos   (IDX_W'(k)),
            .i_left  (left),
            .i_right (right),
            .o_entry (entry[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

// File: hw/rtl/iira_cell.sv
// one storage cell of the list, shifting with its neighbours
`default_nettype none

module iira_cell
    import iira_pkg::*;
(
    input  wire                      i_clk,
    input  t_cell_cmd                i_cmd,
    input  wire [IDX_W-1:0]          i_pos,
    input  wire logic signed [31:0]  i_left,
    input  wire logic signed [31:0]  i_right,
    output logic signed [31:0]       o_entry
);

    logic signed [31:0] r_entry;
    logic signed [31:0] n_entry;

    always_comb begin
        n_entry = r_entry;
        unique case (i_cmd.op)
            CELL_HOLD: begin
                n_entry = r_entry;
            end
            CELL_WRITE: begin
                if (i_pos == i_cmd.pos) begin
                    n_entry = i_cmd.word;
                end
            end
            CELL_INSERT: begin
                if (i_pos == i_cmd.pos) begin
                    n_entry = i_cmd.word;
                end else if (i_pos > i_cmd.pos) begin
                    n_entry = i_left;
                end
            end
            CELL_REMOVE: begin
                if (i_pos >= i_cmd.pos) begin
                    n_entry = i_right;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

// File: hw/rtl/iira_checker.sv
// port checker for the indexed insert remove array unit, with its bind
`default_nettype none

`include "indexed_insert_remove_array_unit_assert.svh"

module iira_checker
    import iira_pkg::*;
(
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       o_out_valid,
    input wire       i_out_ready,
    input t_out_item o_out_item
);

    logic empty_ok;
    logic status_ok;
    logic rejected;
    logic stalled;

    assign empty_ok  = o_out_item.is_empty == (o_out_item.count == 5'd0);
    assign status_ok = o_out_item.status == ST_OK || o_out_item.status == ST_RANGE ||
                       o_out_item.status == ST_FULL;
    assign rejected  = o_out_valid && o_out_item.status != ST_OK;
    assign stalled   = o_out_valid && !i_out_ready;

    `IIRA_ASSERT_IMP(a_empty_flag, i_clk, i_rst_n, o_out_valid, empty_ok)
    `IIRA_ASSERT_IMP(a_status_code, i_clk, i_rst_n, o_out_valid, status_ok)
    `IIRA_ASSERT_IMP(a_reject_no_data, i_clk, i_rst_n, rejected, o_out_item.read_value == 32'sd0)
    `IIRA_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, stalled, o_out_valid && $stable(o_out_item))

endmodule

bind indexed_insert_remove_array_unit iira_checker u_iira_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

`default_nettype wire
